FILE: rtl/gbom_pkg.sv
`timescale 1ns / 1ps

package gbom_pkg;

  // largest glyph box side handled by default
  localparam int unsigned MAX_GLYPH_DIM = 255;

  // opacity at or above this is treated as fully opaque
  localparam logic [7:0] NEAR_OPAQUE = 8'd253;

  // register map, one word per register
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned ADDR_W   = $clog2(NUM_REGS) + 2;

  typedef enum logic [2:0] {
    REG_BPP            = 3'd0,
    REG_OPACITY        = 3'd1,
    REG_GLYPH_WIDTH    = 3'd2,
    REG_GLYPH_HEIGHT   = 3'd3,
    REG_CLIP_COL_START = 3'd4,
    REG_CLIP_COL_END   = 3'd5,
    REG_CLIP_ROW_START = 3'd6,
    REG_CLIP_ROW_END   = 3'd7
  } reg_idx_t;

  // pixel depth as log2 of bits per pixel
  typedef enum logic [1:0] {
    DEPTH_1 = 2'd0,
    DEPTH_2 = 2'd1,
    DEPTH_4 = 2'd2,
    DEPTH_8 = 2'd3
  } depth_t;

  // classified byte travelling from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       depth_ok;
    depth_t     depth;
    logic [2:0] last_slot;
  } entry_t;

  // settings used while unpacking
  typedef struct packed {
    logic [7:0] opacity;
    logic [7:0] glyph_width;
    logic [7:0] glyph_height;
    logic [7:0] clip_col_start;
    logic [7:0] clip_col_end;
    logic [7:0] clip_row_start;
    logic [7:0] clip_row_end;
  } cfg_t;

endpackage

FILE: rtl/glyph_bitmap_to_opacity_mask_core.sv
`timescale 1ns / 1ps

// Unpacks a font glyph bitmap into 8-bit opacity mask values.
// Input channel (in_valid/in_ready): one packed bitmap byte per request,
// row-major, most significant pixel first; glyph_start restarts the position.
// Output channel (out_valid/out_ready): one request per pixel inside the
// clip window, with its column and row; last marks the final pixel of a
// byte and glyph_end the final pixel of the glyph.
// The user must write settings over the register port only while no byte is
// in flight; the block itself does not enforce this. Throughput: one pixel
// slot per cycle unless a receiver stall fills the hold and output registers;
// a byte has 8 slots at 1 bpp, 4 at 2 bpp, 2 at 4 bpp and 1 at 8 bpp.
// A pixel waits in the hold register to settle its last flag, then is output.
// A two-entry byte queue lets bytes be taken while results wait.
// When the receiver stalls, the output and hold registers fill, the walker
// stops and the queue backs up to in_ready.
// Reset restores the register defaults, clears the position and empties
// the queue and output.
module glyph_bitmap_to_opacity_mask_core #(
  parameter int unsigned MAX_GLYPH_DIM = gbom_pkg::MAX_GLYPH_DIM
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbom_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  bitmap_byte,
  input  logic                        glyph_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  mask_value,
  output logic [7:0]                  column,
  output logic [7:0]                  row,
  output logic                        last,
  output logic                        glyph_end
);

  logic [3:0]         bits_per_pixel;
  gbom_pkg::cfg_t     cfg;
  gbom_pkg::reg_idx_t reg_idx;
  logic               wr_en;
  logic               head_valid;
  gbom_pkg::entry_t   head;
  logic               pop;

  assign pready  = 1'b1;
  assign reg_idx = gbom_pkg::reg_idx_t'(paddr[gbom_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel     <= 4'd4;
      cfg.opacity        <= 8'd255;
      cfg.glyph_width    <= 8'd0;
      cfg.glyph_height   <= 8'd0;
      cfg.clip_col_start <= 8'd0;
      cfg.clip_col_end   <= 8'd255;
      cfg.clip_row_start <= 8'd0;
      cfg.clip_row_end   <= 8'd255;
    end else if (wr_en) begin
      case (reg_idx)
        gbom_pkg::REG_BPP:            bits_per_pixel     <= pwdata[3:0];
        gbom_pkg::REG_OPACITY:        cfg.opacity        <= pwdata[7:0];
        gbom_pkg::REG_GLYPH_WIDTH:    cfg.glyph_width    <= pwdata[7:0];
        gbom_pkg::REG_GLYPH_HEIGHT:   cfg.glyph_height   <= pwdata[7:0];
        gbom_pkg::REG_CLIP_COL_START: cfg.clip_col_start <= pwdata[7:0];
        gbom_pkg::REG_CLIP_COL_END:   cfg.clip_col_end   <= pwdata[7:0];
        gbom_pkg::REG_CLIP_ROW_START: cfg.clip_row_start <= pwdata[7:0];
        gbom_pkg::REG_CLIP_ROW_END:   cfg.clip_row_end   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      gbom_pkg::REG_BPP:            prdata = {28'd0, bits_per_pixel};
      gbom_pkg::REG_OPACITY:        prdata = {24'd0, cfg.opacity};
      gbom_pkg::REG_GLYPH_WIDTH:    prdata = {24'd0, cfg.glyph_width};
      gbom_pkg::REG_GLYPH_HEIGHT:   prdata = {24'd0, cfg.glyph_height};
      gbom_pkg::REG_CLIP_COL_START: prdata = {24'd0, cfg.clip_col_start};
      gbom_pkg::REG_CLIP_COL_END:   prdata = {24'd0, cfg.clip_col_end};
      gbom_pkg::REG_CLIP_ROW_START: prdata = {24'd0, cfg.clip_row_start};
      gbom_pkg::REG_CLIP_ROW_END:   prdata = {24'd0, cfg.clip_row_end};
      default:                      prdata = 32'd0;
    endcase
  end

  // byte intake and classification
  gbom_front u_front (
    .clk            (clk),
    .rst            (rst),
    .bits_per_pixel (bits_per_pixel),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .bitmap_byte    (bitmap_byte),
    .glyph_start    (glyph_start),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop)
  );

  // pixel walk and coverage scaling
  gbom_back #(
    .MAX_DIM (MAX_GLYPH_DIM)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mask_value (mask_value),
    .column     (column),
    .row        (row),
    .last       (last),
    .glyph_end  (glyph_end)
  );

endmodule

FILE: rtl/gbom_front.sv
`timescale 1ns / 1ps

module gbom_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          bits_per_pixel,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          bitmap_byte,
  input  logic                glyph_start,
  output logic                head_valid,
  output gbom_pkg::entry_t    head,
  input  logic                pop
);

  gbom_pkg::entry_t q [2];
  gbom_pkg::entry_t entry_in;
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  // classify the byte by the current pixel depth
  always_comb begin
    entry_in.data  = bitmap_byte;
    entry_in.start = glyph_start;
    case (bits_per_pixel)
      4'd1: begin
        entry_in.depth_ok  = 1'b1;
        entry_in.depth     = gbom_pkg::DEPTH_1;
        entry_in.last_slot = 3'd7;
      end
      4'd2: begin
        entry_in.depth_ok  = 1'b1;
        entry_in.depth     = gbom_pkg::DEPTH_2;
        entry_in.last_slot = 3'd3;
      end
      4'd3, 4'd4: begin
        entry_in.depth_ok  = 1'b1;
        entry_in.depth     = gbom_pkg::DEPTH_4;
        entry_in.last_slot = 3'd1;
      end
      4'd8: begin
        entry_in.depth_ok  = 1'b1;
        entry_in.depth     = gbom_pkg::DEPTH_8;
        entry_in.last_slot = 3'd0;
      end
      default: begin
        entry_in.depth_ok  = 1'b0;
        entry_in.depth     = gbom_pkg::DEPTH_8;
        entry_in.last_slot = 3'd0;
      end
    endcase
  end

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  // two-entry queue towards the unpacker
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry_in;
    end
  end

endmodule

FILE: rtl/gbom_back.sv
`timescale 1ns / 1ps

module gbom_back #(
  parameter int unsigned MAX_DIM = gbom_pkg::MAX_GLYPH_DIM
) (
  input  logic             clk,
  input  logic             rst,
  input  gbom_pkg::cfg_t   cfg,
  input  logic             head_valid,
  input  gbom_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       mask_value,
  output logic [7:0]       column,
  output logic [7:0]       row,
  output logic             last,
  output logic             glyph_end
);

  // position state
  logic [2:0] slot;
  logic [7:0] col_cnt;
  logic [7:0] row_cnt;
  logic       fin;

  // result waiting to learn whether it closes its byte
  logic       hold_valid;
  logic       hold_closed;
  logic [7:0] hold_mask;
  logic [7:0] hold_col;
  logic [7:0] hold_row;
  logic       hold_end;

  logic [7:0] w_cap;
  logic [7:0] h_cap;
  logic       clr;
  logic [7:0] c0;
  logic [7:0] r0;
  logic       f0;
  logic [8:0] c1;
  logic [8:0] r1;
  logic [8:0] c2;
  logic [8:0] r2;
  logic [7:0] c_next;
  logic [7:0] r_next;
  logic       f_next;
  logic       stop;
  logic       is_end;
  logic       visible;
  logic       byte_done;
  logic       out_free;
  logic       step;
  logic       hold_move;
  logic [5:0] shamt_wide;
  logic [7:0] shifted;
  logic [7:0] cov;
  logic [15:0] prod;
  logic [7:0] pix_mask;

  // box size limited to the largest supported side
  assign w_cap = (32'(cfg.glyph_width) > MAX_DIM) ? 8'(MAX_DIM) : cfg.glyph_width;
  assign h_cap = (32'(cfg.glyph_height) > MAX_DIM) ? 8'(MAX_DIM) : cfg.glyph_height;

  // walk one pixel slot of the head byte
  always_comb begin
    clr     = (slot == 3'd0) && head.start;
    c0      = clr ? 8'd0 : col_cnt;
    r0      = clr ? 8'd0 : row_cnt;
    f0      = clr ? 1'b0 : fin;
    c1      = {1'b0, c0};
    r1      = {1'b0, r0};
    c2      = c1;
    r2      = r1;
    c_next  = c0;
    r_next  = r0;
    f_next  = f0;
    stop    = 1'b0;
    is_end  = 1'b0;
    visible = 1'b0;
    if (!head.depth_ok || f0) begin
      stop = 1'b1;
    end else begin
      if ({1'b0, c0} >= {1'b0, w_cap}) begin
        c1 = 9'd0;
        r1 = {1'b0, r0} + 9'd1;
      end
      if ((w_cap == 8'd0) || (r1 >= {1'b0, h_cap})) begin
        // glyph box exhausted before this slot
        f_next = 1'b1;
        c_next = c1[7:0];
        r_next = r1[7:0];
        stop   = 1'b1;
      end else begin
        c2 = c1 + 9'd1;
        r2 = r1;
        if (c2 >= {1'b0, w_cap}) begin
          c2 = 9'd0;
          r2 = r1 + 9'd1;
        end
        is_end  = (r2 >= {1'b0, h_cap});
        f_next  = is_end;
        c_next  = c2[7:0];
        r_next  = r2[7:0];
        visible = (c1[7:0] >= cfg.clip_col_start) && (c1[7:0] < cfg.clip_col_end) &&
                  (r1[7:0] >= cfg.clip_row_start) && (r1[7:0] < cfg.clip_row_end);
      end
    end
    byte_done = stop || is_end || (slot == head.last_slot);
  end

  // coverage of the current slot
  always_comb begin
    shamt_wide = {3'b000, slot} << head.depth;
    shifted    = head.data << shamt_wide[2:0];
    case (head.depth)
      gbom_pkg::DEPTH_1: cov = shifted[7] ? 8'hFF : 8'h00;
      gbom_pkg::DEPTH_2: cov = 8'({6'd0, shifted[7:6]} * 8'd85);
      gbom_pkg::DEPTH_4: cov = 8'({4'd0, shifted[7:4]} * 8'd17);
      gbom_pkg::DEPTH_8: cov = shifted;
      default:           cov = shifted;
    endcase
    prod = {8'd0, cov} * {8'd0, cfg.opacity};
    if (cfg.opacity < gbom_pkg::NEAR_OPAQUE) begin
      pix_mask = (cov == 8'hFF) ? cfg.opacity : prod[15:8];
    end else begin
      pix_mask = cov;
    end
  end

  // handshake between slot walk, hold stage and output register
  assign out_free  = !out_valid || out_ready;
  assign step      = head_valid && (!hold_valid || out_free);
  assign hold_move = hold_valid && out_free && (hold_closed || (step && visible));
  assign pop       = step && byte_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= 3'd0;
      col_cnt     <= 8'd0;
      row_cnt     <= 8'd0;
      fin         <= 1'b0;
      hold_valid  <= 1'b0;
      hold_closed <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        col_cnt <= c_next;
        row_cnt <= r_next;
        fin     <= f_next;
        slot    <= byte_done ? 3'd0 : slot + 3'd1;
      end
      if (hold_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (step && visible) begin
        hold_valid  <= 1'b1;
        hold_closed <= byte_done;
      end else if (hold_move) begin
        hold_valid <= 1'b0;
      end else if (step && byte_done && hold_valid) begin
        hold_closed <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step && visible) begin
      hold_mask <= pix_mask;
      hold_col  <= c1[7:0];
      hold_row  <= r1[7:0];
      hold_end  <= is_end;
    end
    if (hold_move) begin
      mask_value <= hold_mask;
      column     <= hold_col;
      row        <= hold_row;
      glyph_end  <= hold_end;
      last       <= hold_closed;
    end
  end

endmodule

FILE: rtl/gbom_checker.sv
`timescale 1ns / 1ps

module gbom_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] mask_value,
  input logic [7:0] column,
  input logic [7:0] row,
  input logic       last,
  input logic       glyph_end
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mask_value) && $stable(column) &&
      $stable(row) && $stable(last) && $stable(glyph_end))
    else $error("stalled result changed");

  // the final glyph pixel always closes its byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && glyph_end |-> last)
    else $error("glyph end without last");

  // reset empties the output
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind glyph_bitmap_to_opacity_mask_core gbom_checker u_gbom_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .mask_value (mask_value),
  .column     (column),
  .row        (row),
  .last       (last),
  .glyph_end  (glyph_end)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 48;

  // one expected mask pixel
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] col;
    logic [7:0] row;
    logic       last_px;
    logic       end_px;
  } pixel_t;

  logic                          clk;
  logic                          rst         = 1'b1;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [gbom_pkg::ADDR_W-1:0]   paddr       = '0;
  logic [31:0]                   pwdata      = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  logic [7:0]                    bitmap_byte = '0;
  logic                          glyph_start = 1'b0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  logic [7:0]                    mask_value;
  logic [7:0]                    column;
  logic [7:0]                    row;
  logic                          last;
  logic                          glyph_end;

  // shadow of the register file, reset values
  logic [3:0]     bpp_reg    = 4'd4;
  gbom_pkg::cfg_t shadow_cfg = '{opacity: 8'd255, glyph_width: 8'd0, glyph_height: 8'd0,
                                 clip_col_start: 8'd0, clip_col_end: 8'd255,
                                 clip_row_start: 8'd0, clip_row_end: 8'd255};

  // position through the glyph box
  int unsigned pos_col    = 0;
  int unsigned pos_row    = 0;
  logic        glyph_done = 1'b0;

  pixel_t pending_pixels[$];

  int err_cnt        = 0;
  int bytes_sent     = 0;
  int pixels_checked = 0;
  int settings_cnt   = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;

  glyph_bitmap_to_opacity_mask_core dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .bitmap_byte (bitmap_byte),
    .glyph_start (glyph_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mask_value  (mask_value),
    .column      (column),
    .row         (row),
    .last        (last),
    .glyph_end   (glyph_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop for a hung run
  initial begin
    #3000000;
    $display("tb: done, errors");
    $finish;
  end

  // coverage level to 0..255, then opacity scaling
  function automatic logic [7:0] coverage_of(logic [7:0] level, gbom_pkg::depth_t d);
    logic [15:0] cov;
    case (d)
      gbom_pkg::DEPTH_1: cov = (level != 0) ? 16'd255 : 16'd0;
      gbom_pkg::DEPTH_2: cov = level * 16'd85;
      gbom_pkg::DEPTH_4: cov = level * 16'd17;
      default:           cov = {8'd0, level};
    endcase
    if (shadow_cfg.opacity < gbom_pkg::NEAR_OPAQUE) begin
      if (cov == 16'd255) cov = {8'd0, shadow_cfg.opacity};
      else cov = (cov * {8'd0, shadow_cfg.opacity}) >> 8;
    end
    return cov[7:0];
  endfunction

  // walk the pixel slots of one accepted byte and queue the visible ones
  task automatic unpack_byte(input logic [7:0] b, input logic gs);
    gbom_pkg::depth_t d;
    logic             ok;
    int               bits;
    int               slots;
    int               n;
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    logic [7:0]       lvl;
    logic             at_end;
    pixel_t           px;
    ok = 1'b1;
    n  = 0;
    d  = gbom_pkg::DEPTH_8;
    w  = (shadow_cfg.glyph_width > gbom_pkg::MAX_GLYPH_DIM) ?
         gbom_pkg::MAX_GLYPH_DIM : shadow_cfg.glyph_width;
    h  = (shadow_cfg.glyph_height > gbom_pkg::MAX_GLYPH_DIM) ?
         gbom_pkg::MAX_GLYPH_DIM : shadow_cfg.glyph_height;
    if (gs) begin
      pos_col    = 0;
      pos_row    = 0;
      glyph_done = 1'b0;
    end
    case (bpp_reg)
      4'd1:       d = gbom_pkg::DEPTH_1;
      4'd2:       d = gbom_pkg::DEPTH_2;
      4'd3, 4'd4: d = gbom_pkg::DEPTH_4;
      4'd8:       d = gbom_pkg::DEPTH_8;
      default:    ok = 1'b0;
    endcase
    if (ok) begin
      bits  = 1 << int'(d);
      slots = 8 >> int'(d);
      for (int s = 0; s < slots; s++) begin
        if (glyph_done) break;
        if (pos_col >= w) begin
          pos_col = 0;
          pos_row++;
        end
        if (w == 0 || pos_row >= h) begin
          glyph_done = 1'b1;
          break;
        end
        lvl = 8'((int'(b) >> (8 - bits * (s + 1))) & ((1 << bits) - 1));
        c = pos_col;
        r = pos_row;
        pos_col++;
        if (pos_col >= w) begin
          pos_col = 0;
          pos_row++;
        end
        at_end = (pos_row >= h);
        if (at_end) glyph_done = 1'b1;
        if (c >= shadow_cfg.clip_col_start && c < shadow_cfg.clip_col_end &&
            r >= shadow_cfg.clip_row_start && r < shadow_cfg.clip_row_end) begin
          px = '{value: coverage_of(lvl, d), col: c[7:0], row: r[7:0],
                 last_px: 1'b0, end_px: at_end};
          pending_pixels.push_back(px);
          n++;
        end
      end
      if (n > 0) pending_pixels[$].last_px = 1'b1;
    end
  endtask

  // one register write: setup then access
  task automatic write_reg(input gbom_pkg::reg_idx_t idx, input logic [7:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      gbom_pkg::REG_BPP:            bpp_reg = val[3:0];
      gbom_pkg::REG_OPACITY:        shadow_cfg.opacity = val;
      gbom_pkg::REG_GLYPH_WIDTH:    shadow_cfg.glyph_width = val;
      gbom_pkg::REG_GLYPH_HEIGHT:   shadow_cfg.glyph_height = val;
      gbom_pkg::REG_CLIP_COL_START: shadow_cfg.clip_col_start = val;
      gbom_pkg::REG_CLIP_COL_END:   shadow_cfg.clip_col_end = val;
      gbom_pkg::REG_CLIP_ROW_START: shadow_cfg.clip_row_start = val;
      default:                      shadow_cfg.clip_row_end = val;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // wait for every expected pixel, then let the block go quiet
  task automatic wait_idle();
    int cnt;
    cnt      = 0;
    in_valid = 1'b0;
    while (pending_pixels.size() != 0 && cnt < IDLE_LIMIT) begin
      @(negedge clk);
      cnt++;
    end
    if (pending_pixels.size() != 0) begin
      $display("%0t: missing pixels: expected 0 outstanding, actual %0d",
               $time, pending_pixels.size());
      err_cnt++;
      pending_pixels.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_glyph(input logic [7:0] bpp, input logic [7:0] opa,
                           input logic [7:0] w, input logic [7:0] h,
                           input logic [7:0] ccs, input logic [7:0] cce,
                           input logic [7:0] crs, input logic [7:0] cre);
    wait_idle();
    write_reg(gbom_pkg::REG_BPP, bpp);
    write_reg(gbom_pkg::REG_OPACITY, opa);
    write_reg(gbom_pkg::REG_GLYPH_WIDTH, w);
    write_reg(gbom_pkg::REG_GLYPH_HEIGHT, h);
    write_reg(gbom_pkg::REG_CLIP_COL_START, ccs);
    write_reg(gbom_pkg::REG_CLIP_COL_END, cce);
    write_reg(gbom_pkg::REG_CLIP_ROW_START, crs);
    write_reg(gbom_pkg::REG_CLIP_ROW_END, cre);
    settings_cnt++;
  endtask

  // one bitmap byte request, with a random idle gap in front
  task automatic send_byte(input logic [7:0] b, input logic gs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    bitmap_byte = b;
    glyph_start = gs;
    do @(posedge clk); while (!in_ready);
    unpack_byte(b, gs);
    bytes_sent++;
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // compare each mask pixel request with the oldest expectation
  always @(posedge clk) begin
    pixel_t px;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, actual value %0d col %0d row %0d",
                 $time, mask_value, column, row);
        err_cnt++;
      end else begin
        px = pending_pixels.pop_front();
        check_field("mask_value", px.value, mask_value);
        check_field("column", px.col, column);
        check_field("row", px.row, row);
        check_field("last", px.last_px, last);
        check_field("glyph_end", px.end_px, glyph_end);
        pixels_checked++;
      end
    end
  end

  // every supported depth, padding bits and unsupported depths
  task automatic test_depths();
    set_glyph(8'd1, 8'd255, 8'd3, 8'd2, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'hB4, 1'b1);
    set_glyph(8'd2, 8'd255, 8'd3, 8'd1, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'hE4, 1'b1);
    send_byte(8'h1B, 1'b0);
    set_glyph(8'd3, 8'd255, 8'd3, 8'd1, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hF0, 1'b0);
    set_glyph(8'd4, 8'd255, 8'd2, 8'd2, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'h0F, 1'b1);
    send_byte(8'h7C, 1'b0);
    set_glyph(8'd8, 8'd255, 8'd2, 8'd1, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    // unsupported depths give nothing
    set_glyph(8'd0, 8'd255, 8'd2, 8'd2, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'hFF, 1'b1);
    set_glyph(8'd15, 8'd255, 8'd2, 8'd2, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'h81, 1'b1);
    set_glyph(8'd5, 8'd255, 8'd2, 8'd2, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'h3C, 1'b1);
  endtask

  // opacity around the near-opaque threshold
  task automatic test_opacity();
    logic [7:0] opa_list[4];
    opa_list = '{8'd0, 8'd128, 8'd252, 8'd253};
    foreach (opa_list[i]) begin
      set_glyph(8'd2, opa_list[i], 8'd4, 8'd1, 8'd0, 8'd255, 8'd0, 8'd255);
      send_byte(8'h1B, 1'b1);
    end
  endtask

  // empty glyph, empty clip window, hidden last pixel
  task automatic test_empty_cases();
    set_glyph(8'd1, 8'd255, 8'd0, 8'd4, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'hFF, 1'b1);
    set_glyph(8'd1, 8'd255, 8'd4, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'hFF, 1'b1);
    set_glyph(8'd1, 8'd255, 8'd4, 8'd2, 8'd2, 8'd2, 8'd0, 8'd255);
    send_byte(8'hFF, 1'b1);
    set_glyph(8'd1, 8'd200, 8'd4, 8'd2, 8'd0, 8'd255, 8'd0, 8'd1);
    send_byte(8'hAA, 1'b1);
  endtask

  // box shrunk under the current position between bytes
  task automatic test_shrunk_box();
    set_glyph(8'd1, 8'd255, 8'd12, 8'd4, 8'd0, 8'd255, 8'd0, 8'd255);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    write_reg(gbom_pkg::REG_GLYPH_WIDTH, 8'd4);
    send_byte(8'h96, 1'b0);
    wait_idle();
    write_reg(gbom_pkg::REG_GLYPH_HEIGHT, 8'd3);
    send_byte(8'hFF, 1'b0);
  endtask

  // random settings with the extremes mixed in
  task automatic random_settings();
    logic [7:0] bpp;
    logic [7:0] opa;
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] ccs;
    logic [7:0] cce;
    logic [7:0] crs;
    logic [7:0] cre;
    case ($urandom_range(9))
      0:       bpp = 8'($urandom_range(15));
      1, 2:    bpp = 8'd1;
      3, 4:    bpp = 8'd2;
      5:       bpp = 8'd3;
      6, 7:    bpp = 8'd4;
      default: bpp = 8'd8;
    endcase
    case ($urandom_range(5))
      0:       opa = 8'd0;
      1:       opa = 8'd255;
      2:       opa = 8'($urandom_range(252, 253));
      default: opa = 8'($urandom);
    endcase
    case ($urandom_range(15))
      0:       w = 8'd0;
      1:       w = 8'd255;
      default: w = 8'($urandom_range(1, 6));
    endcase
    case ($urandom_range(15))
      0:       h = 8'd0;
      1:       h = 8'd255;
      default: h = 8'($urandom_range(1, 4));
    endcase
    if ($urandom_range(3) == 0) begin
      ccs = 8'd0;
      cce = 8'd255;
      crs = 8'd0;
      cre = 8'd255;
    end else begin
      ccs = ($urandom_range(15) == 0) ? 8'd255 : 8'($urandom_range(0, 4));
      cce = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(1, 7));
      crs = 8'($urandom_range(0, 2));
      cre = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(0, 4));
    end
    set_glyph(bpp, opa, w, h, ccs, cce, crs, cre);
  endtask

  // mostly whole glyphs with random content, some broken or padded streams
  task automatic test_random(input int send_pct, input int stall_in, input int n_bytes);
    int target;
    int bits;
    int need;
    send_idle_pct = send_pct;
    stall_pct     = stall_in;
    target        = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if (settings_cnt == 0 || $urandom_range(9) < 7) random_settings();
      case (bpp_reg)
        4'd1:       bits = 1;
        4'd2:       bits = 2;
        4'd3, 4'd4: bits = 4;
        4'd8:       bits = 8;
        default:    bits = 2;
      endcase
      need = (int'(shadow_cfg.glyph_width) * int'(shadow_cfg.glyph_height) * bits + 7) / 8;
      if (need > 24) need = $urandom_range(2, 6);
      if (need == 0) need = 1;
      if ($urandom_range(9) == 0) need = need + $urandom_range(1, 2);
      for (int i = 0; i < need; i++) begin
        if (i == 0) send_byte(8'($urandom), ($urandom_range(9) != 0));
        else send_byte(8'($urandom), ($urandom_range(19) == 0));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_depths();
    test_opacity();
    test_empty_cases();
    test_shrunk_box();
    test_random(0, 0, 22);
    test_random(60, 0, 22);
    test_random(0, 60, 22);
    test_random(28, 28, 22);
    wait_idle();
    $display("tb: %0d bitmap bytes over %0d register settings, %0d mask pixels compared",
             bytes_sent, settings_cnt, pixels_checked);
    $display("tb: depths 1/2/3/4/8 and unsupported, clip, opacity and box changes covered");
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
